// ===== rtl/core/nrd_pkg.sv =====
package nrd_pkg;

	// Raster formats, by configuration code
	typedef enum logic [1:0] {
		FMT_P1 = 2'd0,
		FMT_P2 = 2'd1,
		FMT_P4 = 2'd2,
		FMT_P5 = 2'd3
	} fmt_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_OK    = 2'd1,
		KIND_MORE  = 2'd2,
		KIND_LESS  = 2'd3
	} kind_t;

	// Commands passed from the front end to the back end
	typedef enum logic [1:0] {
		OP_NOP  = 2'd0,
		OP_PIX  = 2'd1,
		OP_BITS = 2'd2,
		OP_END  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] value;
		logic       pend;
	} cmd_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DIM_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_NL   = 8'h0A;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_1    = 8'h31;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [7:0] PIX_WHITE = 8'hFF;
	localparam logic [7:0] PIX_BLACK = 8'h00;
	localparam logic [7:0] BIT_MSB   = 8'h80;

endpackage

// ===== rtl/core/nrd_stream_if.sv =====
interface nrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, data_byte, end_of_data, input ready);
	modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface nrd_pixel_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] pixel;
	logic       last;

	modport source (output valid, kind, pixel, last, input ready);
	modport sink (input valid, kind, pixel, last, output ready);
endinterface

// ===== rtl/core/netpbm_raster_decoder.sv =====
// Netpbm raster decoder: takes the raster bytes of a P1, P2, P4 or P5 image, one
// byte per transaction, and returns 8-bit pixels in row-major order on the result
// channel, then one status (ok, too much, too little) for the end marker. Bytes
// enter a text front end at one per cycle while the queue has room and are queued
// (four commands deep) for the pixel back end, whose single result register
// delivers one result per cycle while the channel is ready: P1, P2 and P5 bytes
// sustain one byte per cycle, a P4 byte holds the queue head until its pixels
// are unpacked (up to eight), and an end marker that flushes a pending P2 value
// sends it before the status. A byte's first result passes through the queue and
// the result register. Configure format, width and height through the write port
// while no transaction is in flight; no clearing pass is needed after reset.
module netpbm_raster_decoder #(
	parameter int unsigned MAX_WIDTH  = nrd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = nrd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nrd_byte_if.sink                      byte_ch,
	nrd_pixel_if.source                   pixel_ch,
	input  logic                          cfg_wen,
	input  logic [nrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nrd_pkg::CFG_DIM_W-1:0] cfg_wdata
);
	import nrd_pkg::*;

	fmt_t                 format_q;
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;

	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	// Unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_P1;
			width_q  <= CFG_DIM_W'(1);
			height_q <= CFG_DIM_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FORMAT: format_q <= fmt_t'(cfg_wdata[1:0]);
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	nrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_ch       (byte_ch),
		.raster_format (format_q),
		.queue_full    (full),
		.push          (push),
		.cmd           (wr_cmd)
	);

	nrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (empty)
	);

	nrd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.cmd          (rd_cmd),
		.cmd_valid    (!empty),
		.pop          (pop),
		.pixel_ch     (pixel_ch)
	);

endmodule

// ===== rtl/core/nrd_front.sv =====
module nrd_front (
	input  logic           clk,
	input  logic           arst_n,
	nrd_byte_if.sink       byte_ch,
	input  nrd_pkg::fmt_t  raster_format,
	input  logic           queue_full,
	output logic           push,
	output nrd_pkg::cmd_t  cmd
);
	import nrd_pkg::*;

	logic       in_comment_q;
	logic       num_active_q;
	logic [7:0] num_value_q;
	logic       in_comment_d;
	logic       num_active_d;
	logic [7:0] num_value_d;
	logic       is_digit;
	logic [7:0] digit;
	logic [7:0] base;

	assign byte_ch.ready = !queue_full;
	assign push          = byte_ch.valid && !queue_full;

	assign is_digit = (byte_ch.data_byte >= CHAR_0) && (byte_ch.data_byte <= CHAR_9);
	assign digit    = byte_ch.data_byte - CHAR_0;
	assign base     = num_active_q ? num_value_q : 8'd0;

	always_comb begin
		cmd.op       = OP_NOP;
		cmd.value    = byte_ch.data_byte;
		cmd.pend     = 1'b0;
		in_comment_d = in_comment_q;
		num_active_d = num_active_q;
		num_value_d  = num_value_q;
		if (byte_ch.end_of_data) begin
			// flush a pending gray value ahead of the status, then start afresh
			cmd.op       = OP_END;
			cmd.value    = num_value_q;
			cmd.pend     = (raster_format == FMT_P2) && num_active_q;
			in_comment_d = 1'b0;
			num_active_d = 1'b0;
			num_value_d  = 8'd0;
		end else begin
			unique case (raster_format)
				FMT_P1: begin
					if (in_comment_q) begin
						if (byte_ch.data_byte == CHAR_NL) in_comment_d = 1'b0;
					end else if (byte_ch.data_byte == CHAR_HASH) begin
						in_comment_d = 1'b1;
					end else if (byte_ch.data_byte == CHAR_0 || byte_ch.data_byte == CHAR_1) begin
						cmd.op    = OP_PIX;
						cmd.value = (byte_ch.data_byte == CHAR_1) ? PIX_BLACK : PIX_WHITE;
					end
				end
				FMT_P2: begin
					if (in_comment_q) begin
						if (byte_ch.data_byte == CHAR_NL) in_comment_d = 1'b0;
					end else if (is_digit) begin
						num_active_d = 1'b1;
						num_value_d  = 8'((base << 3) + (base << 1) + digit);
					end else begin
						if (num_active_q) begin
							cmd.op       = OP_PIX;
							cmd.value    = num_value_q;
							num_active_d = 1'b0;
							num_value_d  = 8'd0;
						end
						if (byte_ch.data_byte == CHAR_HASH) in_comment_d = 1'b1;
					end
				end
				FMT_P4: cmd.op = OP_BITS;
				FMT_P5: cmd.op = OP_PIX;
				default: cmd.op = OP_NOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			num_active_q <= 1'b0;
			num_value_q  <= 8'd0;
		end else if (push) begin
			in_comment_q <= in_comment_d;
			num_active_q <= num_active_d;
			num_value_q  <= num_value_d;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && byte_ch.end_of_data) |=> (!in_comment_q && !num_active_q))
		else $error("text state survived an end marker");

endmodule

// ===== rtl/core/nrd_queue.sv =====
module nrd_queue #(
	parameter int unsigned DEPTH = nrd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nrd_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output nrd_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);
	import nrd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop) rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("command queue overrun or underrun");

endmodule

// ===== rtl/core/nrd_back.sv =====
module nrd_back #(
	parameter int unsigned MAX_WIDTH  = nrd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = nrd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nrd_pkg::CFG_DIM_W-1:0] image_width,
	input  logic [nrd_pkg::CFG_DIM_W-1:0] image_height,
	input  nrd_pkg::cmd_t                 cmd,
	input  logic                          cmd_valid,
	output logic                          pop,
	nrd_pixel_if.source                   pixel_ch
);
	import nrd_pkg::*;

	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam longint unsigned MAX_PIX = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam int unsigned PW  = $clog2(MAX_PIX + 1);
	localparam int unsigned DWW = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
	localparam int unsigned DHW = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;

	logic [DWW-1:0]   w_ext;
	logic [DHW-1:0]   h_ext;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;
	logic [WW+HW-1:0] prod;
	logic [PW-1:0]    size_q;

	logic [PW-1:0] pc_q, pc_d, pc_inc;
	logic [CW-1:0] col_q, col_d, col_eff, col_next;
	logic [WW-1:0] col_inc;
	logic          excess_q, excess_d;
	logic [2:0]    bit_q, bit_d;
	logic          phase_q, phase_d;
	logic          full, full_after, stop;

	logic          act;
	logic          emit;
	kind_t         e_kind;
	logic [7:0]    e_pixel;
	logic          e_last;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [7:0]    pixel_q;
	logic          last_q;

	// Clamp the header size to 1..MAX
	always_comb begin
		w_ext = DWW'(image_width);
		h_ext = DHW'(image_height);
		if (w_ext == '0) w_ext = DWW'(1);
		else if (w_ext > DWW'(MAX_WIDTH)) w_ext = DWW'(MAX_WIDTH);
		if (h_ext == '0) h_ext = DHW'(1);
		else if (h_ext > DHW'(MAX_HEIGHT)) h_ext = DHW'(MAX_HEIGHT);
		w = WW'(w_ext);
		h = HW'(h_ext);
	end

	assign prod = (WW+HW)'(w) * (WW+HW)'(h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= PW'(1);
		else size_q <= PW'(prod);
	end

	assign col_eff    = (WW'(col_q) >= w) ? '0 : col_q;
	assign col_inc    = WW'(col_eff) + 1'b1;
	assign col_next   = (col_inc == w) ? '0 : CW'(col_inc);
	assign pc_inc     = pc_q + 1'b1;
	assign full       = (pc_q >= size_q);
	assign full_after = (pc_inc >= size_q);
	assign stop       = (col_next == '0) || (bit_q == 3'd7) || full_after;

	assign act = cmd_valid && (!out_valid_q || pixel_ch.ready);

	always_comb begin
		pop      = 1'b0;
		emit     = 1'b0;
		e_kind   = KIND_PIXEL;
		e_pixel  = cmd.value;
		e_last   = 1'b1;
		pc_d     = pc_q;
		col_d    = col_eff;
		excess_d = excess_q;
		bit_d    = bit_q;
		phase_d  = phase_q;
		if (act) begin
			unique case (cmd.op)
				OP_NOP: pop = 1'b1;
				OP_PIX: begin
					pop = 1'b1;
					if (full) begin
						excess_d = 1'b1;
					end else begin
						emit  = 1'b1;
						pc_d  = pc_inc;
						col_d = col_next;
					end
				end
				OP_BITS: begin
					// one pixel a cycle while the output is free, MSB first, stopping at the row end, the byte end or the image end
					e_pixel = ((cmd.value << bit_q) & BIT_MSB) != 8'd0 ? PIX_BLACK : PIX_WHITE;
					if (bit_q == 3'd0 && full) begin
						pop      = 1'b1;
						excess_d = 1'b1;
					end else begin
						emit   = 1'b1;
						e_last = stop;
						pc_d   = pc_inc;
						col_d  = col_next;
						if (stop) begin
							pop   = 1'b1;
							bit_d = 3'd0;
							if (full_after && col_next != '0 && bit_q != 3'd7) excess_d = 1'b1;
						end else begin
							bit_d = bit_q + 1'b1;
						end
					end
				end
				OP_END: begin
					if (cmd.pend && !phase_q) begin
						phase_d = 1'b1;
						if (full) begin
							excess_d = 1'b1;
						end else begin
							emit   = 1'b1;
							e_last = 1'b0;
							pc_d   = pc_inc;
							col_d  = col_next;
						end
					end else begin
						pop     = 1'b1;
						emit    = 1'b1;
						e_pixel = 8'd0;
						if (excess_q) e_kind = KIND_MORE;
						else if (pc_q != size_q) e_kind = KIND_LESS;
						else e_kind = KIND_OK;
						pc_d     = '0;
						col_d    = '0;
						excess_d = 1'b0;
						phase_d  = 1'b0;
					end
				end
				default: pop = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			col_q    <= '0;
			excess_q <= 1'b0;
			bit_q    <= 3'd0;
			phase_q  <= 1'b0;
		end else if (act) begin
			pc_q     <= pc_d;
			col_q    <= col_d;
			excess_q <= excess_d;
			bit_q    <= bit_d;
			phase_q  <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (pixel_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			pixel_q <= e_pixel;
			last_q  <= e_last;
		end
	end

	assign pixel_ch.valid = out_valid_q;
	assign pixel_ch.kind  = 2'(kind_q);
	assign pixel_ch.pixel = pixel_q;
	assign pixel_ch.last  = last_q;

	a_pixel_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind == KIND_PIXEL) |=> (pc_q == $past(pc_inc)))
		else $error("pixel sent without advancing the count");

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind != KIND_PIXEL) |=> (pc_q == '0 && !excess_q && bit_q == 3'd0))
		else $error("image state not cleared after status");

endmodule
